// File: hw/rtl/cron_next_fire_search_core_assert.svh
// Assertion macros used by the cron search datapath (cnfs_dp).
// Expects clk_i and rst_ni in the scope of use.
`ifndef CRON_NEXT_FIRE_SEARCH_CORE_ASSERT_SVH
`define CRON_NEXT_FIRE_SEARCH_CORE_ASSERT_SVH

// plain invariant
`define CNFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cause at one edge, effect at the next
`define CNFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cnfs_pkg.sv
// Types, constants and calendar helpers for the cron next-fire search.
// No dependencies.
`default_nettype none
package cnfs_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 60;
  localparam int unsigned WdW     = 3;
  localparam int unsigned SumW    = 15;

  localparam logic [YearW-1:0]  YearMax   = 14'd9999;
  localparam logic [CountW-1:0] CountMax  = 7'd64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MINUTE  = 3'd0,
    REG_HOUR    = 3'd1,
    REG_DOM     = 3'd2,
    REG_MONTH   = 3'd3,
    REG_WEEKDAY = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WD1,
    OP_WD2,
    OP_WD3,
    OP_WD4,
    OP_CLAMP,
    OP_ADV,
    OP_STEP,
    OP_NF
  } op_e;

  typedef struct packed {
    logic in_ready;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic count_zero;
    logic dirty;
    logic past_end;
    logic iter_done;
    logic count_done;
    logic out_free;
  } status_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [WdW-1:0] month_off(input logic [MonthW-1:0] m);
    logic [WdW-1:0] r;
    case (m)
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cnfs_in_if.sv
// Request channel: start moment and wanted count.
// Uses cnfs_pkg widths.
`default_nettype none
interface cnfs_in_if;
  logic                           valid;
  logic                           ready;
  logic [cnfs_pkg::YearW-1:0]     start_year;
  logic [cnfs_pkg::MonthW-1:0]    start_month;
  logic [cnfs_pkg::DayW-1:0]      start_day;
  logic [cnfs_pkg::HourW-1:0]     start_hour;
  logic [cnfs_pkg::MinuteW-1:0]   start_minute;
  logic [cnfs_pkg::CountW-1:0]    result_count;

  modport source (output valid, start_year, start_month, start_day, start_hour,
                  start_minute, result_count, input ready);
  modport sink (input valid, start_year, start_month, start_day, start_hour,
                start_minute, result_count, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cnfs_out_if.sv
// Result channel: one matching time per word.
// Uses cnfs_pkg widths.
`default_nettype none
interface cnfs_out_if;
  logic                           valid;
  logic                           ready;
  logic [cnfs_pkg::YearW-1:0]     fire_year;
  logic [cnfs_pkg::MonthW-1:0]    fire_month;
  logic [cnfs_pkg::DayW-1:0]      fire_day;
  logic [cnfs_pkg::HourW-1:0]     fire_hour;
  logic [cnfs_pkg::MinuteW-1:0]   fire_minute;
  logic                           found;
  logic                           last;

  modport source (output valid, fire_year, fire_month, fire_day, fire_hour,
                  fire_minute, found, last, input ready);
  modport sink (input valid, fire_year, fire_month, fire_day, fire_hour,
                fire_minute, found, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cnfs_ctrl.sv
// Sequencer for the search: load, weekday/leap pipe, one jump per step.
// Depends on cnfs_pkg.
`default_nettype none
module cnfs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cnfs_pkg::status_t status_i,
  output cnfs_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WD1, S_WD2, S_WD3, S_WD4, S_CLAMP, S_ADV, S_CHECK, S_STEP, S_NF
  } state_e;

  state_e state_q;
  logic   init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (status_i.in_fire && !status_i.count_zero) begin
            state_q <= S_WD1;
            init_q  <= 1'b1;
          end
        end
        S_WD1: state_q <= S_WD2;
        S_WD2: state_q <= S_WD3;
        S_WD3: state_q <= S_WD4;
        S_WD4: state_q <= init_q ? S_CLAMP : S_CHECK;
        S_CLAMP: begin
          state_q <= S_ADV;
          init_q  <= 1'b0;
        end
        S_ADV: state_q <= S_CHECK;
        S_CHECK: begin
          if (status_i.count_done) begin
            state_q <= S_IDLE;
          end else if (status_i.past_end || status_i.iter_done) begin
            state_q <= S_NF;
          end else if (status_i.dirty) begin
            state_q <= S_WD1;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (status_i.out_free) state_q <= S_CHECK;
        end
        S_NF: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.in_ready = (state_q == S_IDLE);
    unique case (state_q)
      S_WD1:   cmd_o.op = cnfs_pkg::OP_WD1;
      S_WD2:   cmd_o.op = cnfs_pkg::OP_WD2;
      S_WD3:   cmd_o.op = cnfs_pkg::OP_WD3;
      S_WD4:   cmd_o.op = cnfs_pkg::OP_WD4;
      S_CLAMP: cmd_o.op = cnfs_pkg::OP_CLAMP;
      S_ADV:   cmd_o.op = cnfs_pkg::OP_ADV;
      S_STEP:  cmd_o.op = cnfs_pkg::OP_STEP;
      S_NF:    cmd_o.op = cnfs_pkg::OP_NF;
      default: cmd_o.op = cnfs_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/cnfs_dp.sv
// Datapath: mask registers, calendar position, weekday/leap pipe, output word.
// Depends on cnfs_pkg, cnfs_in_if, cnfs_out_if and the assertion macros.
`default_nettype none
`include "cron_next_fire_search_core_assert.svh"
module cnfs_dp #(
  parameter int unsigned MAX_STEPS = 5256000
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cnfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cnfs_pkg::CfgW-1:0]      cfg_data_i,
  cnfs_in_if.sink                             in_i,
  cnfs_out_if.source                          out_o,
  input  wire cnfs_pkg::cmd_t                 cmd_i,
  output cnfs_pkg::status_t                   status_o
);

  localparam int unsigned IterW = $clog2(MAX_STEPS + 1);
  localparam logic [IterW-1:0] IterMax = IterW'(MAX_STEPS);

  function automatic logic [cnfs_pkg::SumW-1:0] SumW_ext(input logic [cnfs_pkg::YearW-1:0] v);
    return {1'b0, v};
  endfunction

  logic [59:0] mm_q;
  logic [23:0] hm_q;
  logic [30:0] dm_q;
  logic [11:0] mo_q;
  logic [6:0]  wm_q;

  logic [cnfs_pkg::YearW-1:0]   cy_q, cy_d;
  logic [cnfs_pkg::MonthW-1:0]  cmo_q, cmo_d;
  logic [cnfs_pkg::DayW-1:0]    cd_q, cd_d;
  logic [cnfs_pkg::HourW-1:0]   ch_q, ch_d;
  logic [cnfs_pkg::MinuteW-1:0] cmi_q, cmi_d;
  logic pe_q, pe_d, dirty_q, dirty_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [cnfs_pkg::CountW-1:0] n_q, n_d, count_q;

  logic [cnfs_pkg::YearW-1:0] yp_q;
  logic [7:0]  b_q, h_q;
  logic [5:0]  c_q;
  logic [cnfs_pkg::SumW-1:0] s_q;
  logic [12:0] q_q;
  logic leap_q;
  logic [cnfs_pkg::WdW-1:0] wd_q;

  logic out_valid_q, out_found_q, out_last_q;
  logic [cnfs_pkg::YearW-1:0]   out_year_q;
  logic [cnfs_pkg::MonthW-1:0]  out_month_q;
  logic [cnfs_pkg::DayW-1:0]    out_day_q;
  logic [cnfs_pkg::HourW-1:0]   out_hour_q;
  logic [cnfs_pkg::MinuteW-1:0] out_minute_q;

  logic in_fire, out_free, emit_hit, emit_nf;
  logic [cnfs_pkg::DayW-1:0] mlen;

  // first allowed values and next allowed values at or above the current one
  logic [cnfs_pkg::MinuteW-1:0] fm, nxm;
  logic [cnfs_pkg::HourW-1:0]   fh, nxh;
  logic [3:0]                   fmo, nxmo;
  logic okm, okh, okmo;
  logic [59:0] mm_hi;
  logic [23:0] hm_hi;
  logic [11:0] mo_hi;

  always_comb begin
    mm_hi = mm_q & ({60{1'b1}} << cmi_q);
    hm_hi = hm_q & ({24{1'b1}} << ch_q);
    mo_hi = mo_q & ({12{1'b1}} << (cmo_q - 4'd1));
    fm = '0; nxm = '0; okm = 1'b0;
    for (int i = 59; i >= 0; i--) begin
      if (mm_q[i]) fm = 6'(i);
      if (mm_hi[i]) begin
        nxm = 6'(i);
        okm = 1'b1;
      end
    end
    fh = '0; nxh = '0; okh = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (hm_q[i]) fh = 5'(i);
      if (hm_hi[i]) begin
        nxh = 5'(i);
        okh = 1'b1;
      end
    end
    fmo = '0; nxmo = '0; okmo = 1'b0;
    for (int i = 11; i >= 0; i--) begin
      if (mo_q[i]) fmo = 4'(i);
      if (mo_hi[i]) begin
        nxmo = 4'(i);
        okmo = 1'b1;
      end
    end
  end

  // one day on
  logic [cnfs_pkg::YearW-1:0]  di_y;
  logic [cnfs_pkg::MonthW-1:0] di_m;
  logic [cnfs_pkg::DayW-1:0]   di_d;
  logic                        di_pe;
  logic day_ok, dom_ok, dow_ok;

  assign mlen = cnfs_pkg::month_len(cmo_q, leap_q);

  always_comb begin
    di_y = cy_q; di_m = cmo_q; di_d = cd_q + 5'd1; di_pe = 1'b0;
    if (cd_q >= mlen) begin
      di_d = 5'd1;
      if (cmo_q >= 4'd12) begin
        di_m  = 4'd1;
        di_y  = cy_q + 14'd1;
        di_pe = (cy_q >= cnfs_pkg::YearMax);
      end else begin
        di_m = cmo_q + 4'd1;
      end
    end
    dom_ok = dm_q[cd_q - 5'd1];
    dow_ok = wm_q[wd_q];
    if (dm_q != '0 && wm_q != '0) day_ok = dom_ok || dow_ok;
    else if (dm_q != '0)          day_ok = dom_ok;
    else if (wm_q != '0)          day_ok = dow_ok;
    else                          day_ok = 1'b1;
  end

  assign in_fire  = in_i.valid && cmd_i.in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign emit_hit = (cmd_i.op == cnfs_pkg::OP_STEP) && out_free
                    && !(mm_q != '0 && !(okm && nxm == cmi_q))
                    && !(hm_q != '0 && !(okh && nxh == ch_q))
                    && day_ok
                    && !(mo_q != '0 && !(okmo && nxmo + 4'd1 == cmo_q));
  assign emit_nf  = (cmd_i.op == cnfs_pkg::OP_NF) && out_free;

  // next position
  always_comb begin
    cy_d = cy_q; cmo_d = cmo_q; cd_d = cd_q; ch_d = ch_q; cmi_d = cmi_q;
    pe_d = pe_q; iter_d = iter_q; n_d = n_q;
    case (cmd_i.op)
      cnfs_pkg::OP_CLAMP: begin
        if (cd_q > mlen) cd_d = mlen;
      end
      cnfs_pkg::OP_ADV: begin
        if (cmi_q >= 6'd59) begin
          cmi_d = '0;
          if (ch_q >= 5'd23) begin
            ch_d = '0; cy_d = di_y; cmo_d = di_m; cd_d = di_d; pe_d = di_pe;
          end else begin
            ch_d = ch_q + 5'd1;
          end
        end else begin
          cmi_d = cmi_q + 6'd1;
        end
      end
      cnfs_pkg::OP_STEP: begin
        if (out_free) begin
          iter_d = iter_q + 1'b1;
          if (mm_q != '0 && !okm) begin
            cmi_d = fm;
            if (ch_q >= 5'd23) begin
              ch_d = '0; cy_d = di_y; cmo_d = di_m; cd_d = di_d; pe_d = di_pe;
            end else begin
              ch_d = ch_q + 5'd1;
            end
          end else if (mm_q != '0 && nxm != cmi_q) begin
            cmi_d = nxm;
          end else if (hm_q != '0 && !okh) begin
            cy_d = di_y; cmo_d = di_m; cd_d = di_d; pe_d = di_pe; ch_d = fh; cmi_d = fm;
          end else if (hm_q != '0 && nxh != ch_q) begin
            ch_d = nxh; cmi_d = fm;
          end else if (!day_ok) begin
            cy_d = di_y; cmo_d = di_m; cd_d = di_d; pe_d = di_pe; ch_d = fh; cmi_d = fm;
          end else if (mo_q != '0 && !okmo) begin
            cy_d = cy_q + 14'd1; pe_d = (cy_q >= cnfs_pkg::YearMax);
            cmo_d = fmo + 4'd1; cd_d = 5'd1; ch_d = fh; cmi_d = fm;
          end else if (mo_q != '0 && nxmo + 4'd1 != cmo_q) begin
            cmo_d = nxmo + 4'd1; cd_d = 5'd1; ch_d = fh; cmi_d = fm;
          end else begin
            n_d = n_q + 7'd1;
            if (cmi_q >= 6'd59) begin
              cmi_d = '0;
              if (ch_q >= 5'd23) begin
                ch_d = '0; cy_d = di_y; cmo_d = di_m; cd_d = di_d; pe_d = di_pe;
              end else begin
                ch_d = ch_q + 5'd1;
              end
            end else begin
              cmi_d = cmi_q + 6'd1;
            end
          end
        end
      end
      default: ;
    endcase
    dirty_d = dirty_q || (cy_d != cy_q) || (cmo_d != cmo_q) || (cd_d != cd_q);
    if (cmd_i.op == cnfs_pkg::OP_WD4) dirty_d = 1'b0;
  end

  // weekday / leap pipe arithmetic
  logic [26:0] yp_mul, cy_mul;
  logic [24:0] q4_mul;
  logic [29:0] s_mul;
  logic [cnfs_pkg::YearW-1:0] yp_n;
  logic [cnfs_pkg::SumW-1:0]  s_n, wd_diff;
  logic [cnfs_pkg::YearW-1:0] h100;

  always_comb begin
    yp_n   = cy_q - ((cmo_q < 4'd3) ? 14'd1 : 14'd0);
    yp_mul = 27'(yp_n) * 27'd5243;
    q4_mul = 25'(yp_n >> 2) * 25'd5243;
    cy_mul = 27'(cy_q) * 27'd5243;
    s_n    = SumW_ext(yp_q) + SumW_ext(yp_q >> 2) - 15'(b_q) + 15'(c_q)
             + 15'(cnfs_pkg::month_off(cmo_q)) + 15'(cd_q);
    h100   = 14'(h_q) * 14'd100;
    s_mul  = 30'(s_q) * 30'd18725;
    wd_diff = s_q - 15'(q_q) * 15'd7;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q <= '0; hm_q <= '0; dm_q <= '0; mo_q <= '0; wm_q <= '0;
      cy_q <= 14'd1; cmo_q <= 4'd1; cd_q <= 5'd1; ch_q <= '0; cmi_q <= '0;
      pe_q <= 1'b0; dirty_q <= 1'b0; iter_q <= '0; n_q <= '0; count_q <= '0;
      yp_q <= '0; b_q <= '0; h_q <= '0; c_q <= '0; s_q <= '0; q_q <= '0;
      leap_q <= 1'b0; wd_q <= '0;
      out_valid_q <= 1'b0; out_found_q <= 1'b0; out_last_q <= 1'b0;
      out_year_q <= '0; out_month_q <= '0; out_day_q <= '0;
      out_hour_q <= '0; out_minute_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cnfs_pkg::REG_MINUTE:  mm_q <= cfg_data_i[59:0];
          cnfs_pkg::REG_HOUR:    hm_q <= cfg_data_i[23:0];
          cnfs_pkg::REG_DOM:     dm_q <= cfg_data_i[30:0];
          cnfs_pkg::REG_MONTH:   mo_q <= cfg_data_i[11:0];
          cnfs_pkg::REG_WEEKDAY: wm_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        cy_q <= (in_i.start_year == '0) ? 14'd1 :
                (in_i.start_year > cnfs_pkg::YearMax) ? cnfs_pkg::YearMax : in_i.start_year;
        cmo_q <= (in_i.start_month == '0) ? 4'd1 :
                 (in_i.start_month > 4'd12) ? 4'd12 : in_i.start_month;
        cd_q  <= (in_i.start_day == '0) ? 5'd1 : in_i.start_day;
        ch_q  <= (in_i.start_hour > 5'd23) ? 5'd23 : in_i.start_hour;
        cmi_q <= (in_i.start_minute > 6'd59) ? 6'd59 : in_i.start_minute;
        count_q <= (in_i.result_count > cnfs_pkg::CountMax) ? cnfs_pkg::CountMax
                                                             : in_i.result_count;
        pe_q <= 1'b0; dirty_q <= 1'b1; iter_q <= '0; n_q <= '0;
      end else begin
        cy_q <= cy_d; cmo_q <= cmo_d; cd_q <= cd_d; ch_q <= ch_d; cmi_q <= cmi_d;
        pe_q <= pe_d; dirty_q <= dirty_d; iter_q <= iter_d; n_q <= n_d;
      end

      case (cmd_i.op)
        cnfs_pkg::OP_WD1: begin
          yp_q <= yp_n;
          b_q  <= yp_mul[26:19];
          c_q  <= q4_mul[24:19];
          h_q  <= cy_mul[26:19];
        end
        cnfs_pkg::OP_WD2: begin
          s_q    <= s_n;
          leap_q <= (cy_q[1:0] == 2'b00) && ((h100 != cy_q) || (h_q[1:0] == 2'b00));
        end
        cnfs_pkg::OP_WD3: q_q  <= s_mul[29:17];
        cnfs_pkg::OP_WD4: wd_q <= wd_diff[2:0];
        default: ;
      endcase

      if (emit_hit) begin
        out_valid_q  <= 1'b1;
        out_found_q  <= 1'b1;
        out_last_q   <= (n_q + 7'd1 == count_q);
        out_year_q   <= cy_q;
        out_month_q  <= cmo_q;
        out_day_q    <= cd_q;
        out_hour_q   <= ch_q;
        out_minute_q <= cmi_q;
      end else if (emit_nf) begin
        out_valid_q  <= 1'b1;
        out_found_q  <= 1'b0;
        out_last_q   <= 1'b1;
        out_year_q   <= '0;
        out_month_q  <= '0;
        out_day_q    <= '0;
        out_hour_q   <= '0;
        out_minute_q <= '0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_i.ready        = cmd_i.in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.last        = out_last_q;
  assign out_o.fire_year   = out_year_q;
  assign out_o.fire_month  = out_month_q;
  assign out_o.fire_day    = out_day_q;
  assign out_o.fire_hour   = out_hour_q;
  assign out_o.fire_minute = out_minute_q;

  assign status_o.in_fire    = in_fire;
  assign status_o.count_zero = (in_i.result_count == '0);
  assign status_o.dirty      = dirty_q;
  assign status_o.past_end   = pe_q;
  assign status_o.iter_done  = (iter_q == IterMax);
  assign status_o.count_done = (n_q == count_q);
  assign status_o.out_free   = out_free;

  `CNFS_ASSERT(a_fire_time_range, !out_valid_q || !out_found_q || (out_hour_q < 5'd24 && out_minute_q < 6'd60), "fire time out of range")
  `CNFS_ASSERT(a_count_bound, n_q <= count_q, "more matches than requested")
  `CNFS_ASSERT(a_weekday_range, wd_q < 3'd7, "weekday out of range")
  `CNFS_ASSERT_NEXT(a_match_loads_word, emit_hit, out_valid_q && out_found_q, "match not presented")

endmodule
`default_nettype wire

// File: hw/rtl/cron_next_fire_search_core.sv
// Top level of the cron next-fire search: controller plus datapath.
// Depends on cnfs_pkg, cnfs_in_if, cnfs_out_if, cnfs_ctrl and cnfs_dp.
//
//   channel   dir  handshake          word
//   in_i      in   valid/ready        start date, time and count
//   out_o     out  valid/ready        one fire time, found, last
//   cfg_*     in   cfg_we_i only      mask register write
//
// One request at a time; input is taken only when the sequencer is idle.
// Each jump step passes S_STEP and S_CHECK, plus the weekday/leap pipe states
// S_WD1 to S_WD4 after any date change; a request ends after at most MAX_STEPS steps.
// The output word is registered; a stalled sink holds the sequencer in place.
// Reset clears masks to zero and returns the sequencer to idle.
`default_nettype none
module cron_next_fire_search_core #(
  parameter int unsigned MAX_STEPS = 5256000
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cnfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [cnfs_pkg::CfgW-1:0]    cfg_data_i,
  cnfs_in_if.sink                           in_i,
  cnfs_out_if.source                        out_o
);

  cnfs_pkg::cmd_t    cmd;
  cnfs_pkg::status_t status;

  cnfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cnfs_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
`default_nettype wire

// File: tb/tb_cron_next_fire_search_core.sv
// Self-checking testbench for cron_next_fire_search_core: random and directed
// requests over several mask settings, results checked against a scoreboard.
// Depends on cnfs_pkg, cnfs_in_if, cnfs_out_if and the core RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic [cnfs_pkg::YearW-1:0]   year;
  logic [cnfs_pkg::MonthW-1:0]  month;
  logic [cnfs_pkg::DayW-1:0]    day;
  logic [cnfs_pkg::HourW-1:0]   hour;
  logic [cnfs_pkg::MinuteW-1:0] minute;
  logic [cnfs_pkg::CountW-1:0]  count;
} start_req_t;

typedef struct packed {
  logic [cnfs_pkg::YearW-1:0]   year;
  logic [cnfs_pkg::MonthW-1:0]  month;
  logic [cnfs_pkg::DayW-1:0]    day;
  logic [cnfs_pkg::HourW-1:0]   hour;
  logic [cnfs_pkg::MinuteW-1:0] minute;
  logic                         found;
  logic                         last;
} fire_word_t;

class fire_scoreboard;
  int unsigned     step_bound;
  longint unsigned min_m, hour_m, dom_m, mon_m, wd_m;
  int unsigned     cy, cmo, cd, ch, cmi;
  bit              past_end;
  fire_word_t      pending[$];
  int unsigned     n_found, n_missed;

  function new(int unsigned bound);
    step_bound = bound;
    min_m = 0; hour_m = 0; dom_m = 0; mon_m = 0; wd_m = 0;
    n_found = 0; n_missed = 0;
  endfunction

  function void set_mask(cnfs_pkg::reg_idx_e idx, longint unsigned v);
    case (idx)
      cnfs_pkg::REG_MINUTE:  min_m  = v & 64'h0FFF_FFFF_FFFF_FFFF;
      cnfs_pkg::REG_HOUR:    hour_m = v & 64'hFF_FFFF;
      cnfs_pkg::REG_DOM:     dom_m  = v & 64'h7FFF_FFFF;
      cnfs_pkg::REG_MONTH:   mon_m  = v & 64'hFFF;
      cnfs_pkg::REG_WEEKDAY: wd_m   = v & 64'h7F;
      default: ;
    endcase
  endfunction

  function bit leap(int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function int unsigned mlen(int unsigned y, int unsigned m);
    if (m == 2) return leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function int unsigned dow(int unsigned y, int unsigned m, int unsigned d);
    int unsigned off[12];
    off = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    if (m < 3) y = y - 1;
    return (y + y / 4 - y / 100 + y / 400 + off[m-1] + d) % 7;
  endfunction

  function void next_year();
    cy++;
    if (cy > 9999) past_end = 1;
  endfunction

  function void next_day();
    cd++;
    if (cd > mlen(cy, cmo)) begin
      cd = 1;
      cmo++;
      if (cmo > 12) begin
        cmo = 1;
        next_year();
      end
    end
  endfunction

  function void next_hour();
    ch++;
    if (ch > 23) begin
      ch = 0;
      next_day();
    end
  endfunction

  function void next_minute();
    cmi++;
    if (cmi > 59) begin
      cmi = 0;
      next_hour();
    end
  endfunction

  function int lowest_from(longint unsigned m, int unsigned w, int unsigned from);
    for (int unsigned i = from; i < w; i++)
      if (m[i]) return i;
    return -1;
  endfunction

  function int unsigned first_of(longint unsigned m, int unsigned w);
    int v;
    v = lowest_from(m, w, 0);
    return v < 0 ? 0 : v;
  endfunction

  function void push_word(bit hit, bit fin);
    fire_word_t w;
    w = '0;
    if (hit) begin
      w.year = 14'(cy); w.month = 4'(cmo); w.day = 5'(cd); w.hour = 5'(ch);
      w.minute = 6'(cmi);
      n_found++;
    end else begin
      n_missed++;
    end
    w.found = hit;
    w.last  = fin;
    pending.push_back(w);
  endfunction

  function void note_request(start_req_t r);
    int unsigned want, got, fm, fh;
    int nx;
    bit dom_ok, dow_ok, day_ok;
    want = r.count;
    if (want == 0) return;
    if (want > 64) want = 64;
    fm = first_of(min_m, 60);
    fh = first_of(hour_m, 24);
    cy = r.year;
    if (cy < 1) cy = 1;
    if (cy > 9999) cy = 9999;
    cmo = r.month;
    if (cmo < 1) cmo = 1;
    if (cmo > 12) cmo = 12;
    cd = r.day;
    if (cd < 1) cd = 1;
    if (cd > mlen(cy, cmo)) cd = mlen(cy, cmo);
    ch = r.hour;
    if (ch > 23) ch = 23;
    cmi = r.minute;
    if (cmi > 59) cmi = 59;
    past_end = 0;
    got = 0;
    next_minute();
    for (int unsigned it = 0; it < step_bound && got < want && !past_end; it++) begin
      if (min_m != 0) begin
        nx = lowest_from(min_m, 60, cmi);
        if (nx < 0) begin
          cmi = 0; next_hour(); cmi = fm;
          continue;
        end
        if (nx != cmi) begin
          cmi = nx;
          continue;
        end
      end
      if (hour_m != 0) begin
        nx = lowest_from(hour_m, 24, ch);
        if (nx < 0) begin
          next_day(); ch = fh; cmi = fm;
          continue;
        end
        if (nx != ch) begin
          ch = nx; cmi = fm;
          continue;
        end
      end
      dom_ok = dom_m[cd-1];
      dow_ok = wd_m[dow(cy, cmo, cd)];
      if (dom_m != 0 && wd_m != 0) day_ok = dom_ok || dow_ok;
      else if (dom_m != 0) day_ok = dom_ok;
      else if (wd_m != 0) day_ok = dow_ok;
      else day_ok = 1;
      if (!day_ok) begin
        next_day(); ch = fh; cmi = fm;
        continue;
      end
      if (mon_m != 0) begin
        nx = lowest_from(mon_m, 12, cmo - 1);
        if (nx < 0) begin
          next_year();
          cmo = first_of(mon_m, 12) + 1;
          cd = 1; ch = fh; cmi = fm;
          continue;
        end
        if (nx + 1 != cmo) begin
          cmo = nx + 1;
          cd = 1; ch = fh; cmi = fm;
          continue;
        end
      end
      push_word(1, got + 1 == want);
      got++;
      next_minute();
    end
    if (got < want) push_word(0, 1);
  endfunction

  function bit check_word(fire_word_t w, output string msg);
    fire_word_t e;
    msg = "";
    if (pending.size() == 0) begin
      $sformat(msg, "unexpected word %p", w);
      return 0;
    end
    e = pending.pop_front();
    if (w.year   != e.year)   $sformat(msg, "%s year %0d/%0d", msg, w.year, e.year);
    if (w.month  != e.month)  $sformat(msg, "%s month %0d/%0d", msg, w.month, e.month);
    if (w.day    != e.day)    $sformat(msg, "%s day %0d/%0d", msg, w.day, e.day);
    if (w.hour   != e.hour)   $sformat(msg, "%s hour %0d/%0d", msg, w.hour, e.hour);
    if (w.minute != e.minute) $sformat(msg, "%s minute %0d/%0d", msg, w.minute, e.minute);
    if (w.found  != e.found)  $sformat(msg, "%s found %0d/%0d", msg, w.found, e.found);
    if (w.last   != e.last)   $sformat(msg, "%s last %0d/%0d", msg, w.last, e.last);
    return msg == "";
  endfunction
endclass

module tb_cron_next_fire_search_core;

  localparam int unsigned StepBound = 1000;
  localparam int unsigned Stall     = 150000;
  localparam int unsigned Settle    = 64;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [cnfs_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cnfs_pkg::CfgW-1:0]     cfg_data;

  cnfs_in_if  in_if ();
  cnfs_out_if out_if ();

  cron_next_fire_search_core #(.MAX_STEPS(StepBound)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  fire_scoreboard sb;
  int unsigned errors;
  int unsigned n_req;
  int unsigned cycle;
  int unsigned quiet;
  bit          calm;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  task automatic report(string msg);
    errors++;
    $display("[%0t] mismatch:%s", $time, msg);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.start_year = '0; in_if.start_month = '0; in_if.start_day = '0;
    in_if.start_hour = '0; in_if.start_minute = '0; in_if.result_count = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
  end

  // sink side, word check and watchdog
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      cycle++;
      calm = cycle > 20000 && cycle < 60000;
      if (out_if.valid && out_if.ready) begin
        if (!sb.check_word({out_if.fire_year, out_if.fire_month, out_if.fire_day,
                            out_if.fire_hour, out_if.fire_minute, out_if.found,
                            out_if.last}, msg))
          report(msg);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= Stall) begin
        $display("watchdog: no traffic for %0d cycles", Stall);
        $display("TEST FAILED");
        $finish;
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  task automatic write_reg(logic [cnfs_pkg::CfgIdxW-1:0] idx, logic [cnfs_pkg::CfgW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    sb.set_mask(cnfs_pkg::reg_idx_e'(idx), v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic send(start_req_t r);
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.start_year   <= r.year;
    in_if.start_month  <= r.month;
    in_if.start_day    <= r.day;
    in_if.start_hour   <= r.hour;
    in_if.start_minute <= r.minute;
    in_if.result_count <= r.count;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(r);
    n_req++;
  endtask

  function automatic start_req_t mk(int y, int mo, int d, int h, int mi, int c);
    start_req_t r;
    r.year = 14'(y); r.month = 4'(mo); r.day = 5'(d); r.hour = 5'(h);
    r.minute = 6'(mi); r.count = 7'(c);
    return r;
  endfunction

  function automatic logic [cnfs_pkg::CfgW-1:0] rand_mask(int unsigned w);
    logic [cnfs_pkg::CfgW-1:0] v;
    v = 60'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = (v & ~((60'd1 << w) - 60'd1)) | (60'd1 << $urandom_range(0, w - 1));
      3: v = v & 60'({$urandom, $urandom}) & 60'({$urandom, $urandom});
      default: ;
    endcase
    return v;
  endfunction

  function automatic start_req_t rand_req();
    start_req_t r;
    r = 41'({$urandom, $urandom});
    if ($urandom_range(0, 9) < 8) begin
      r.year   = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(9997, 9999))
                                              : 14'($urandom_range(1, 9999));
      r.month  = 4'($urandom_range(1, 12));
      r.day    = 5'($urandom_range(1, 31));
      r.hour   = 5'($urandom_range(0, 23));
      r.minute = 6'($urandom_range(0, 59));
    end
    case ($urandom_range(0, 19))
      0:               r.count = 7'd0;
      1, 2:            r.count = 7'($urandom_range(64, 127));
      3, 4, 5, 6, 7:   r.count = 7'($urandom_range(5, 16));
      default:         r.count = 7'($urandom_range(1, 4));
    endcase
    return r;
  endfunction

  task automatic set_all(logic [cnfs_pkg::CfgW-1:0] mi, logic [cnfs_pkg::CfgW-1:0] h,
                         logic [cnfs_pkg::CfgW-1:0] dm, logic [cnfs_pkg::CfgW-1:0] mo,
                         logic [cnfs_pkg::CfgW-1:0] wd);
    write_reg(cnfs_pkg::REG_MINUTE, mi);
    write_reg(cnfs_pkg::REG_HOUR, h);
    write_reg(cnfs_pkg::REG_DOM, dm);
    write_reg(cnfs_pkg::REG_MONTH, mo);
    write_reg(cnfs_pkg::REG_WEEKDAY, wd);
  endtask

  initial begin
    sb = new(StepBound);
    errors = 0; n_req = 0; cycle = 0; quiet = 0; calm = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: everything open
    send(mk(1, 1, 1, 0, 0, 1));
    send(mk(9999, 12, 31, 23, 59, 3));
    send(mk(2024, 5, 5, 5, 5, 0));
    send(mk(2023, 12, 31, 23, 58, 127));
    send(mk(0, 0, 0, 0, 0, 2));
    send(mk(16383, 15, 31, 31, 63, 2));
    send(mk(2000, 2, 31, 23, 59, 2));
    send(mk(1900, 2, 30, 23, 59, 2));
    drain();
    // indexes beyond the register map are ignored
    write_reg(3'd5, '1);
    write_reg(3'd7, '1);
    // impossible: day 31 of February only
    set_all(60'd1, 60'd1, 60'd1 << 30, 60'd1 << 1, 60'd0);
    send(mk(2020, 1, 1, 0, 0, 1));
    send(mk(9999, 1, 1, 0, 0, 4));
    drain();
    // day of month OR weekday, January only, year wrap
    set_all(60'd1 << 59, 60'd1 << 23, 60'd1 << 12, 60'd1, 60'd1 << 5);
    send(mk(2023, 12, 20, 0, 0, 4));
    send(mk(2024, 1, 31, 23, 59, 2));
    drain();
    // all ones everywhere, high garbage bits included
    set_all('1, '1, '1, '1, '1);
    send(mk(2024, 2, 28, 23, 59, 5));
    send(mk(9999, 12, 31, 23, 57, 64));
    drain();
    // sparse minutes and hours, weekday only
    set_all((60'd1 << 0) | (60'd1 << 30), (60'd1 << 3) | (60'd1 << 17), 60'd0,
            60'd0, 60'd1 << 0);
    send(mk(2021, 6, 15, 17, 31, 6));
    send(mk(2021, 6, 15, 2, 0, 3));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      set_all(rand_mask(60), rand_mask(24), rand_mask(31), rand_mask(12), rand_mask(7));
      for (int k = 0; k < 11; k++) send(rand_req());
      drain();
    end

    $display("requests %0d; words matched %0d, search-exhausted %0d",
             n_req, sb.n_found, sb.n_missed);
    $display("masks: open, impossible, day/weekday OR, all-ones, sparse and 12 random sets");
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("errors %0d, words still expected %0d", errors, sb.pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: cron_next_fire_search_core.f
+incdir+hw/rtl
hw/rtl/cnfs_pkg.sv
hw/rtl/cnfs_in_if.sv
hw/rtl/cnfs_out_if.sv
hw/rtl/cnfs_ctrl.sv
hw/rtl/cnfs_dp.sv
hw/rtl/cron_next_fire_search_core.sv
tb/tb_cron_next_fire_search_core.sv
